// File: sv/cpa_pkg.sv
// shared types and constants of the contrastive pair accuracy block
package cpa_pkg;

    localparam int CNT_W     = 17;
    localparam int ACC_W     = 48;
    localparam int SQ_W      = 32;
    localparam int FRAC_BITS = 16;
    localparam int IN_W      = 32;
    localparam int USER_W    = 2;
    localparam int OUT_W     = 120;
    localparam int CFG_W     = 32;

    localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};
    localparam logic [ACC_W-1:0] ACC_MAX = {ACC_W{1'b1}};

    // register indexes of the configuration port
    localparam logic CFG_MARGIN = 1'b0;
    localparam logic CFG_LEGACY = 1'b1;

    typedef logic [CNT_W-1:0] count_t;

    // per-batch counts handed from the front to the back
    typedef struct packed {
        count_t pos_pairs;
        count_t neg_pairs;
        count_t pos_correct;
        count_t neg_correct;
    } batch_counts_t;

    // queue status seen by both sides
    typedef struct packed {
        logic empty;
        logic free1;
        logic free2;
    } q_stat_t;

    // result word, last field in the lowest bits
    typedef struct packed {
        logic   pad;
        count_t neg_correct;
        count_t pos_correct;
        count_t neg_pairs;
        count_t pos_pairs;
        count_t neg_rate;
        count_t pos_rate;
        count_t mean_accuracy;
    } result_t;

endpackage

// File: sv/cpa_queue.sv
// short queue of batch counts between the front and the back
module cpa_queue
    import cpa_pkg::*;
#(
    parameter int DEPTH = 2
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  batch_counts_t push_data,
    input  logic          pop,
    output batch_counts_t head,
    output q_stat_t       stat
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int FILL_W = $clog2(DEPTH + 1);

    batch_counts_t mem [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg;
    logic [PTR_W-1:0]  rd_ptr_reg;
    logic [FILL_W-1:0] fill_reg;

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                fill_reg <= fill_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                fill_reg <= fill_reg - 1'b1;
            end
        end
    end

    assign head       = mem[rd_ptr_reg];
    assign stat.empty = (fill_reg == '0);
    assign stat.free1 = (int'(fill_reg) < DEPTH);
    assign stat.free2 = (int'(fill_reg) + 2 <= DEPTH);

endmodule

// File: sv/cpa_front.sv
// front: accepts element words, accumulates squared distance, scores pairs
module cpa_front
    import cpa_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic              cfg_index,
    input  logic [CFG_W-1:0]  cfg_data,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic signed [15:0] a_value,
    input  logic signed [15:0] b_value,
    input  logic              similar,
    input  logic              pair_end,
    input  logic              batch_end,
    input  q_stat_t           qstat,
    output logic              push,
    output batch_counts_t     push_data
);

    logic [31:0]       margin_reg;
    logic              legacy_reg;
    logic [63:0]       margin_sq_reg;

    logic              s1_valid_reg;
    logic [SQ_W-1:0]   s1_sq_reg;
    logic              s1_sim_reg;
    logic              s1_close_reg;
    logic              s1_bend_reg;

    logic [ACC_W-1:0]  dist_reg;
    count_t            pos_count_reg;
    count_t            neg_count_reg;
    count_t            pos_right_reg;
    count_t            neg_right_reg;

    logic              accept;
    logic signed [16:0] diff;
    logic [16:0]       mag;
    logic [SQ_W-1:0]   sq;
    logic [ACC_W:0]    sum;
    logic [ACC_W-1:0]  dist_new;
    logic              pos_ok;
    logic              neg_ok;
    count_t            pos_count_next;
    count_t            neg_count_next;
    count_t            pos_right_next;
    count_t            neg_right_next;

    // a pending batch end in stage 1 needs a second free slot
    assign in_ready = (s1_valid_reg && s1_bend_reg) ? qstat.free2 : qstat.free1;
    assign accept   = in_valid && in_ready;

    assign diff = 17'(signed'({a_value[15], a_value})) - 17'(signed'({b_value[15], b_value}));
    assign mag  = diff[16] ? 17'(-diff) : 17'(diff);
    assign sq   = mag[15:0] * mag[15:0];

    // saturating accumulate, then score the closing pair
    always_comb
    begin
        sum      = {1'b0, dist_reg} + (ACC_W + 1)'(s1_sq_reg);
        dist_new = sum[ACC_W] ? ACC_MAX : sum[ACC_W-1:0];
        pos_ok   = dist_new < ACC_W'(margin_reg);
        if (legacy_reg)
        begin
            neg_ok = dist_new >= ACC_W'(margin_reg);
        end
        else
        begin
            neg_ok = {dist_new, 16'b0} >= margin_sq_reg;
        end

        pos_count_next = pos_count_reg;
        neg_count_next = neg_count_reg;
        pos_right_next = pos_right_reg;
        neg_right_next = neg_right_reg;
        if (s1_valid_reg && s1_close_reg)
        begin
            if (s1_sim_reg)
            begin
                if (pos_count_reg != CNT_MAX)
                begin
                    pos_count_next = pos_count_reg + 1'b1;
                    if (pos_ok)
                    begin
                        pos_right_next = pos_right_reg + 1'b1;
                    end
                end
            end
            else
            begin
                if (neg_count_reg != CNT_MAX)
                begin
                    neg_count_next = neg_count_reg + 1'b1;
                    if (neg_ok)
                    begin
                        neg_right_next = neg_right_reg + 1'b1;
                    end
                end
            end
        end
    end

    assign push                  = s1_valid_reg && s1_bend_reg;
    assign push_data.pos_pairs   = pos_count_next;
    assign push_data.neg_pairs   = neg_count_next;
    assign push_data.pos_correct = pos_right_next;
    assign push_data.neg_correct = neg_right_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            margin_reg <= 32'd65536;
            legacy_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_MARGIN: margin_reg <= cfg_data;
                CFG_LEGACY: legacy_reg <= cfg_data[0];
                default:    ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        margin_sq_reg <= margin_reg * margin_reg;
        if (accept)
        begin
            s1_sq_reg    <= sq;
            s1_sim_reg   <= similar;
            s1_close_reg <= pair_end || batch_end;
            s1_bend_reg  <= batch_end;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            dist_reg      <= '0;
            pos_count_reg <= '0;
            neg_count_reg <= '0;
            pos_right_reg <= '0;
            neg_right_reg <= '0;
        end
        else
        begin
            s1_valid_reg <= accept;
            if (s1_valid_reg)
            begin
                if (s1_bend_reg)
                begin
                    dist_reg      <= '0;
                    pos_count_reg <= '0;
                    neg_count_reg <= '0;
                    pos_right_reg <= '0;
                    neg_right_reg <= '0;
                end
                else
                begin
                    dist_reg      <= s1_close_reg ? '0 : dist_new;
                    pos_count_reg <= pos_count_next;
                    neg_count_reg <= neg_count_next;
                    pos_right_reg <= pos_right_next;
                    neg_right_reg <= neg_right_next;
                end
            end
        end
    end

`ifndef NO_ASSERTIONS
    a_pos_right_le_count: assert property (@(posedge clk) disable iff (!rst_n)
        pos_right_reg <= pos_count_reg)
        else $error("pos right count above pos count");
    a_neg_right_le_count: assert property (@(posedge clk) disable iff (!rst_n)
        neg_right_reg <= neg_count_reg)
        else $error("neg right count above neg count");
    a_push_has_room: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> qstat.free1)
        else $error("batch pushed into a full queue");
`endif

endmodule

// File: sv/cpa_back.sv
// back: divides the batch counts into accuracies and holds the result word
module cpa_back
    import cpa_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  q_stat_t       qstat,
    input  batch_counts_t head,
    output logic          pop,
    output logic          out_valid,
    input  logic          out_ready,
    output result_t       out_word
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_INIT,
        ST_STEP,
        ST_ROUND,
        ST_DONE
    } state_t;

    state_t        state_reg;
    logic          phase_reg;
    logic [4:0]    cnt_reg;
    count_t        rem_reg;
    logic [17:0]   quo_reg;
    batch_counts_t batch_reg;
    count_t        pos_acc_reg;
    count_t        neg_acc_reg;
    logic          out_valid_reg;
    result_t       out_reg;

    count_t        sel_right;
    count_t        sel_total;
    logic          init_ge;
    logic [17:0]   rem2;
    logic          take;
    logic [17:0]   rounded;
    count_t        frac;
    logic [17:0]   mean_sum;
    logic          out_free;

    always_comb
    begin
        sel_right = phase_reg ? batch_reg.neg_correct : batch_reg.pos_correct;
        sel_total = phase_reg ? batch_reg.neg_pairs : batch_reg.pos_pairs;
        init_ge   = sel_right >= sel_total;
        rem2      = {rem_reg, 1'b0};
        take      = rem2 >= {1'b0, sel_total};
        rounded   = quo_reg + 18'd1;
        frac      = (sel_total == '0) ? '0 : rounded[17:1];
        mean_sum  = 18'(pos_acc_reg) + 18'(neg_acc_reg) + 18'd1;
    end

    assign out_free  = !out_valid_reg || out_ready;
    assign pop       = (state_reg == ST_IDLE) && !qstat.empty;
    assign out_valid = out_valid_reg;
    assign out_word  = out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            phase_reg     <= 1'b0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            // in ST_DONE the load below decides the valid
            if (out_valid_reg && out_ready && (state_reg != ST_DONE))
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE:
                begin
                    if (!qstat.empty)
                    begin
                        batch_reg <= head;
                        phase_reg <= 1'b0;
                        state_reg <= ST_INIT;
                    end
                end
                ST_INIT:
                begin
                    // quotient top bit: right never exceeds total
                    rem_reg   <= init_ge ? CNT_W'(sel_right - sel_total) : sel_right;
                    quo_reg   <= {17'b0, init_ge};
                    cnt_reg   <= '0;
                    state_reg <= ST_STEP;
                end
                ST_STEP:
                begin
                    rem_reg <= take ? CNT_W'(rem2 - {1'b0, sel_total}) : rem2[CNT_W-1:0];
                    quo_reg <= {quo_reg[16:0], take};
                    cnt_reg <= cnt_reg + 1'b1;
                    if (cnt_reg == 5'(FRAC_BITS))
                    begin
                        state_reg <= ST_ROUND;
                    end
                end
                ST_ROUND:
                begin
                    if (phase_reg)
                    begin
                        neg_acc_reg <= frac;
                        state_reg   <= ST_DONE;
                    end
                    else
                    begin
                        pos_acc_reg <= frac;
                        phase_reg   <= 1'b1;
                        state_reg   <= ST_INIT;
                    end
                end
                ST_DONE:
                begin
                    if (out_free)
                    begin
                        out_reg.pad           <= 1'b0;
                        out_reg.mean_accuracy <= mean_sum[17:1];
                        out_reg.pos_rate      <= pos_acc_reg;
                        out_reg.neg_rate      <= neg_acc_reg;
                        out_reg.pos_pairs     <= batch_reg.pos_pairs;
                        out_reg.neg_pairs     <= batch_reg.neg_pairs;
                        out_reg.pos_correct   <= batch_reg.pos_correct;
                        out_reg.neg_correct   <= batch_reg.neg_correct;
                        out_valid_reg         <= 1'b1;
                        state_reg             <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

`ifndef NO_ASSERTIONS
    a_step_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_STEP) |-> (cnt_reg <= 5'(FRAC_BITS)))
        else $error("divider step count out of range");
    a_out_correct_le_pairs: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_reg.pos_correct <= out_reg.pos_pairs
                           && out_reg.neg_correct <= out_reg.neg_pairs))
        else $error("result correct count above pair count");
    a_out_acc_bound: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_reg.pos_rate <= 17'd65536
                           && out_reg.neg_rate <= 17'd65536))
        else $error("accuracy above one");
`endif

endmodule

// File: sv/contrastive_pair_accuracy.sv
// top level of the contrastive pair accuracy block
// usage:
//   s_* takes one element word per ready cycle: one element of each embedding
//   of a pair, pair label and pair end flag in s_tuser, batch end on s_tlast
//   cfg_* writes margin (index 0, unsigned q16.16) and legacy mode (index 1)
//   m_* gives one result word per batch: accuracies in q1.16 and the counts
// throughput: one element word per cycle while the batch queue has room; the
//   back divides one batch at a time, so runs of short batches fill the queue
// a batch's result word goes through one front stage, the queue pop, the
//   shared bit-serial divider (two divisions, one after the other) and the
//   output load
// a pair's squared distance is accumulated in a two-stage front, scored when
//   the pair closes, and the batch counts go through a short queue to the back
// the queue lets the front run on while the back divides or while the
//   receiver stalls m_*; s_tready drops when the queue is full, or when one
//   slot is left and a batch end sits in the front stage
// reset clears counts, queue, divider and the output valid, and loads
//   margin 1.0 and legacy mode off
// configuration must be written only while no batch is in flight; not enforced
module contrastive_pair_accuracy
    import cpa_pkg::*;
#(
    parameter int QUEUE_DEPTH = 2
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic              cfg_index,
    input  logic [CFG_W-1:0]  cfg_data,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [IN_W-1:0]   s_tdata,   // a_value, b_value
    input  logic [USER_W-1:0] s_tuser,   // similar, pair_end
    input  logic              s_tlast,   // batch_end
    output logic              m_tvalid,
    input  logic              m_tready,
    // mean_accuracy, pos_rate, neg_rate, pos_pairs, neg_pairs,
    // pos_correct, neg_correct, zero pad bit
    output logic [OUT_W-1:0]  m_tdata
);

    q_stat_t       qstat;
    logic          push;
    batch_counts_t push_data;
    logic          pop;
    batch_counts_t head;
    result_t       out_word;

    // front: element words in, batch counts out
    cpa_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .a_value   (s_tdata[15:0]),
        .b_value   (s_tdata[31:16]),
        .similar   (s_tuser[0]),
        .pair_end  (s_tuser[1]),
        .batch_end (s_tlast),
        .qstat     (qstat),
        .push      (push),
        .push_data (push_data)
    );

    // batch counts waiting for the divider
    cpa_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .head      (head),
        .stat      (qstat)
    );

    // back: divisions, rounding and the output register
    cpa_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .qstat     (qstat),
        .head      (head),
        .pop       (pop),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_word  (out_word)
    );

    assign m_tdata = out_word;

endmodule
